>>> src/rli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rli_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
package rli_pkg;

   localparam int DefTableSize = 32;
   localparam int DefEntryBits = 16;
   localparam int PixelBits    = 8;
   localparam int PixelMax     = 255;
   localparam int FracBits     = 8;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture accepted word
      logic rd_lo;     // read low neighbour row for current channel
      logic rd_hi;     // read high neighbour row for current channel
      logic mac_lo;    // accumulate low term
      logic mac_hi;    // accumulate high term
      logic div_start; // start the serial divide
      logic div_step;  // one quotient bit
      logic store;     // store quotient for current channel
      logic wr_row;    // write the table row
      logic publish;   // move the finished pixel into the output register
      logic [1:0] chan;
   } rli_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_pixel;
      logic row_ok;
      logic flat;
      logic num_pos;
   } rli_sts_type;

endpackage

>>> src/rli_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rli_datapath
// table memory, min/max tracking, interpolation and serial divide
// ----------------------------------------------------------------------------
module rli_datapath
   import rli_pkg::*;
#(
   parameter int TABLE_SIZE = DefTableSize,
   parameter int ENTRY_BITS = DefEntryBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [80:0] in_word,
   input  rli_cmd_type cmd,
   output rli_sts_type sts,
   output logic [7:0]  out_red,
   output logic [7:0]  out_green,
   output logic [7:0]  out_blue
);

   localparam int IdxBits = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int NumBits = ENTRY_BITS + FracBits + 1;
   localparam int ScBits  = PixelBits + IdxBits;

   typedef logic [ENTRY_BITS-1:0] ent_type;

   // table memory, one entry per channel
   ent_type mem_r [TABLE_SIZE];
   ent_type mem_g [TABLE_SIZE];
   ent_type mem_b [TABLE_SIZE];

   logic [80:0]         word_ff;
   ent_type             min_ff, max_ff;
   ent_type             rd_ff;
   logic [NumBits-1:0]  acc_ff, acc_in;
   logic [7:0]          res_ff [3];
   logic [7:0]          out_ff [3];

   // fields of the captured word
   logic [7:0]          row;
   logic [7:0]          samp;
   ent_type             e_r, e_g, e_b;
   assign row  = word_ff[8:1];
   assign e_r  = ent_type'(word_ff[24:9]);
   assign e_g  = ent_type'(word_ff[40:25]);
   assign e_b  = ent_type'(word_ff[56:41]);
   always_comb begin
      case (cmd.chan)
         2'd0:    samp = word_ff[64:57];
         2'd1:    samp = word_ff[72:65];
         default: samp = word_ff[80:73];
      endcase
   end

   // position of the sample in the table: constant divide by 255
   logic [ScBits-1:0]   scaled;
   logic [IdxBits:0]    lo_q;
   logic [7:0]          frac;
   logic [ScBits+1:0]   tmp;
   logic [IdxBits-1:0]  lo_idx, hi_idx;
   always_comb begin
      scaled = ScBits'(samp) * ScBits'(TABLE_SIZE - 1);
      // q = (x + (x>>8) + 1) >> 8 is exact for x < 65535
      tmp    = (ScBits+2)'(scaled) + (ScBits+2)'(scaled >> 8) + (ScBits+2)'(1);
      lo_q   = (IdxBits+1)'(tmp >> 8);
      frac   = 8'(scaled - ScBits'(lo_q) * ScBits'(PixelMax));
      lo_idx = IdxBits'(lo_q);
      if (lo_q >= (IdxBits+1)'(TABLE_SIZE - 1)) hi_idx = IdxBits'(TABLE_SIZE - 1);
      else hi_idx = IdxBits'(lo_q + 1'b1);
   end

   // registered table read
   logic [IdxBits-1:0] rd_addr;
   assign rd_addr = cmd.rd_hi ? hi_idx : lo_idx;
   always_ff @(posedge clock) begin
      if (cmd.wr_row) begin
         mem_r[row[IdxBits-1:0]] <= e_r;
         mem_g[row[IdxBits-1:0]] <= e_g;
         mem_b[row[IdxBits-1:0]] <= e_b;
      end
      if (cmd.rd_lo || cmd.rd_hi) begin
         case (cmd.chan)
            2'd0:    rd_ff <= mem_r[rd_addr];
            2'd1:    rd_ff <= mem_g[rd_addr];
            default: rd_ff <= mem_b[rd_addr];
         endcase
      end
   end

   // signed term (e - min) * weight, summed into the accumulator
   logic signed [ENTRY_BITS+1:0]  diff;
   logic        [8:0]             wgt;
   logic signed [NumBits:0]       prod, acc_s;
   always_comb begin
      diff   = $signed({2'b00, rd_ff}) - $signed({2'b00, min_ff});
      wgt    = cmd.mac_hi ? {1'b0, frac} : 9'(PixelMax) - 9'(frac);
      prod   = (NumBits+1)'(diff * $signed({1'b0, wgt}));
      acc_s  = $signed({acc_ff[NumBits-1], acc_ff});
      acc_in = acc_ff;
      if (cmd.mac_lo) acc_in = NumBits'(prod);
      else if (cmd.mac_hi) acc_in = NumBits'(acc_s + prod);
   end
   assign sts.num_pos = !acc_ff[NumBits-1] && (acc_ff != '0);

   // long division of acc by span, one numerator bit per step, msb first
   ent_type            span;
   logic [NumBits-1:0] shift_ff;
   logic [NumBits-1:0] dr_ff;
   logic [NumBits-1:0] dq_ff;
   logic [NumBits:0]   dshl;
   assign span = max_ff - min_ff;
   always_comb dshl = {dr_ff, shift_ff[NumBits-1]};
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         shift_ff <= acc_ff;
         dr_ff    <= '0;
         dq_ff    <= '0;
      end else if (cmd.div_step) begin
         shift_ff <= {shift_ff[NumBits-2:0], 1'b0};
         if (dshl >= (NumBits+1)'(span)) begin
            dr_ff <= NumBits'(dshl - (NumBits+1)'(span));
            dq_ff <= {dq_ff[NumBits-2:0], 1'b1};
         end else begin
            dr_ff <= NumBits'(dshl);
            dq_ff <= {dq_ff[NumBits-2:0], 1'b0};
         end
      end
   end
   assign sts.flat = (max_ff <= min_ff);

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '1;
         max_ff <= '0;
      end else if (cmd.wr_row) begin
         min_ff <= (e_r < min_ff && e_r <= e_g && e_r <= e_b) ? e_r :
                   (e_g < min_ff && e_g <= e_b) ? e_g :
                   (e_b < min_ff) ? e_b : min_ff;
         max_ff <= (e_r > max_ff && e_r >= e_g && e_r >= e_b) ? e_r :
                   (e_g > max_ff && e_g >= e_b) ? e_g :
                   (e_b > max_ff) ? e_b : max_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.load) word_ff <= in_word;
      acc_ff <= acc_in;
      if (cmd.store) begin
         res_ff[cmd.chan] <= (!sts.num_pos || sts.flat) ? 8'd0 :
                             (dq_ff > NumBits'(PixelMax)) ? 8'(PixelMax) : 8'(dq_ff);
      end
      // output register, free for the next pixel once loaded
      if (cmd.publish) out_ff <= res_ff;
   end

   assign sts.is_pixel = word_ff[0];
   assign sts.row_ok   = (row < 8'(TABLE_SIZE - 1)) || (row == 8'(TABLE_SIZE - 1));
   assign out_red   = out_ff[0];
   assign out_green = out_ff[1];
   assign out_blue  = out_ff[2];

endmodule

>>> src/rli_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rli_control
// sequencer: row write, or per channel read/accumulate/divide
// ----------------------------------------------------------------------------
module rli_control
   import rli_pkg::*;
#(
   parameter int ENTRY_BITS = DefEntryBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   output logic        out_valid,
   input  logic        out_ready,
   output logic        out_flat,
   output rli_cmd_type cmd,
   input  rli_sts_type sts
);

   localparam int NumBits = ENTRY_BITS + FracBits + 1;
   localparam int CntBits = $clog2(NumBits + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RDLO, S_RDHI, S_MACLO, S_MACHI, S_DIV, S_STORE, S_HOLD
   } state_type;

   state_type          state_ff;
   logic [1:0]         chan_ff;
   logic [CntBits-1:0] cnt_ff;
   logic               valid_ff, flat_ff;
   logic               publish;

   // finished pixel moves out once the output register is free or leaving
   assign publish = (state_ff == S_HOLD) && (!valid_ff || out_ready);

   // single clocked block for state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chan_ff  <= 2'd0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
         flat_ff  <= 1'b0;
      end else begin
         if (publish) begin
            valid_ff <= 1'b1;
            flat_ff  <= sts.flat;
         end else if (valid_ff && out_ready) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid && in_ready) state_ff <= S_DECODE;
            end
            S_DECODE: begin
               chan_ff <= 2'd0;
               if (!sts.is_pixel) state_ff <= S_IDLE;
               else state_ff <= S_RDLO;
            end
            S_RDLO:  state_ff <= S_RDHI;
            S_RDHI:  state_ff <= S_MACLO;
            S_MACLO: state_ff <= S_MACHI;
            S_MACHI: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CntBits'(NumBits)) state_ff <= S_STORE;
            end
            S_STORE: begin
               if (chan_ff == 2'd2) begin
                  state_ff <= S_HOLD;
               end else begin
                  chan_ff  <= chan_ff + 2'd1;
                  state_ff <= S_RDLO;
               end
            end
            S_HOLD: begin
               if (publish) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // accept whenever idle; the output register holds the previous word
   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = valid_ff;
   assign out_flat  = flat_ff;

   always_comb begin
      cmd           = '0;
      cmd.chan      = chan_ff;
      cmd.load      = in_valid && in_ready;
      cmd.wr_row    = (state_ff == S_DECODE) && !sts.is_pixel && sts.row_ok;
      cmd.rd_lo     = (state_ff == S_RDLO);
      cmd.rd_hi     = (state_ff == S_RDHI);
      cmd.mac_lo    = (state_ff == S_RDHI);
      cmd.mac_hi    = (state_ff == S_MACLO);
      cmd.div_start = (state_ff == S_MACHI);
      cmd.div_step  = (state_ff == S_DIV) && (cnt_ff != CntBits'(NumBits));
      cmd.store     = (state_ff == S_STORE);
      cmd.publish   = publish;
   end

   // result register never reloads while still held
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> $stable(flat_ff)) else $error("held flag changed");
   assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> chan_ff != 2'd3) else $error("bad channel");

endmodule

>>> src/rgb_lut_interpolate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_lut_interpolate
// per-channel 1d color table with linear interpolation
// ----------------------------------------------------------------------------
// req channel: command 0 writes one table row (three entries) and updates the
// running min/max; command 1 corrects one pixel and gives one rsp word.
// a row write is decoded in the cycle after it is accepted and gives no word;
// the controller then returns to idle for the next word.
// for each channel in turn a pixel reads its two neighbour
// rows from the single table port, forms the interpolated numerator and runs a
// one-bit-per-cycle divide by the table span. once the third channel is stored
// the pixel moves into the output register, rsp_tvalid rises and the
// controller returns to idle for the next word.
// the result sits in an output register; while rsp is stalled new words are
// still accepted and a following pixel waits in its last cycle until the held
// word leaves. reset clears control state, sets min to all ones and max to
// zero; table contents are undefined until written. flat_table marks
// max <= min, with all samples 0.
// ----------------------------------------------------------------------------
module rgb_lut_interpolate
   import rli_pkg::*;
#(
   parameter int TABLE_SIZE = DefTableSize,
   parameter int ENTRY_BITS = DefEntryBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // command
   input  logic [79:0] req_tdata,   // row_index, entry_red/green/blue, pixel r/g/b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // flat_table
   output logic [23:0] rsp_tdata    // out_red, out_green, out_blue
);

   rli_cmd_type cmd;
   rli_sts_type sts;
   logic [7:0]  o_r, o_g, o_b;

   rli_control #(.ENTRY_BITS(ENTRY_BITS)) u_ctl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_flat(rsp_tuser),
      .cmd, .sts
   );

   rli_datapath #(.TABLE_SIZE(TABLE_SIZE), .ENTRY_BITS(ENTRY_BITS)) u_dp (
      .clock, .reset,
      .in_word({req_tdata, req_tuser}),
      .cmd, .sts,
      .out_red(o_r), .out_green(o_g), .out_blue(o_b)
   );

   assign rsp_tdata = {o_b, o_g, o_r};

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the per-channel color table interpolator
// ----------------------------------------------------------------------------
// a directed table of row writes and pixels runs first, then random words:
// mostly full table loads with random entries followed by pixel bursts, plus
// out-of-range row writes. every pixel word is predicted by an exact integer
// model of the normalize-and-interpolate chain and checked field by field.
// ----------------------------------------------------------------------------
module testbench
   import rli_pkg::*;
();

   localparam int NROWS     = DefTableSize;
   localparam int TIMEOUT   = 2000000;
   localparam int RAND_WORDS = 950;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct {
      logic        cmd;
      logic [7:0]  row;
      logic [15:0] ent_r, ent_g, ent_b;
      logic [7:0]  pix_r, pix_g, pix_b;
      logic        known;   // expected result typed in below
      logic        exp_flat;
      pixel_type   exp_pix;
   } vector_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        rsp_tuser;
   logic [23:0] rsp_tdata;

   // model state of the color table
   logic [15:0] lut_entry [NROWS][3];
   logic [15:0] lut_min;
   logic [15:0] lut_max;

   // pending corrected pixels, flat flag in bit 24
   logic [24:0] pending_pixels [$];

   int  cycle_count;
   bit  failed;
   int  stall_pct;
   int  stall_left;

   rgb_lut_interpolate dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT) begin
         $display("FAIL");
         $finish;
      end
   end

   // one channel of the interpolation, exact integer form
   function automatic logic [7:0] interp_channel(input logic [7:0] p, input int ch);
      int unsigned scaled, lo, hi, frac;
      longint d0, d1, num, span, q;
      scaled = p * (NROWS - 1);
      lo = scaled / 255;
      frac = scaled % 255;
      hi = (lo + 1 > NROWS - 1) ? NROWS - 1 : lo + 1;
      d0 = longint'(lut_entry[lo][ch]) - longint'(lut_min);
      d1 = longint'(lut_entry[hi][ch]) - longint'(lut_min);
      num = d0 * (255 - frac) + d1 * frac;
      if (num <= 0) return 8'd0;
      span = longint'(lut_max) - longint'(lut_min);
      q = num / span;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // update table or predict the corrected pixel for one accepted word
   task automatic predict_word(input vector_type v);
      logic [15:0] e [3];
      pixel_type   px;
      e = '{v.ent_r, v.ent_g, v.ent_b};
      if (v.cmd == CMD_WRITE) begin
         if (v.row < NROWS) begin
            for (int c = 0; c < 3; c++) begin
               lut_entry[v.row][c] = e[c];
               if (e[c] < lut_min) lut_min = e[c];
               if (e[c] > lut_max) lut_max = e[c];
            end
         end
      end else if (lut_max <= lut_min) begin
         pending_pixels.insert(pending_pixels.size(), {1'b1, 24'd0});
      end else begin
         px.red   = interp_channel(v.pix_r, 0);
         px.green = interp_channel(v.pix_g, 1);
         px.blue  = interp_channel(v.pix_b, 2);
         pending_pixels.insert(pending_pixels.size(), {1'b0, px});
      end
      if (v.known && v.cmd == CMD_PIXEL &&
          pending_pixels[$] != {v.exp_flat, v.exp_pix}) begin
         $error("directed row: expected %h predicted %h",
                {v.exp_flat, v.exp_pix}, pending_pixels[$]);
         failed = 1'b1;
      end
   endtask

   // drive one word and wait for acceptance
   task automatic send_word(input vector_type v, input bit gaps);
      int gap;
      gap = 0;
      if (gaps)
         gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= v.cmd;
      req_tdata  <= {v.pix_b, v.pix_g, v.pix_r, v.ent_b, v.ent_g, v.ent_r, v.row};
      do @(posedge clock); while (!req_tready);
      predict_word(v);
   endtask

   function automatic vector_type row_word(input logic [7:0] row, input logic [15:0] r,
                                           input logic [15:0] g, input logic [15:0] b);
      vector_type v;
      v = '{CMD_WRITE, row, r, g, b, 8'($urandom), 8'($urandom), 8'($urandom),
            1'b0, 1'b0, '0};
      return v;
   endfunction

   function automatic vector_type pixel_word(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      vector_type v;
      v = '{CMD_PIXEL, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            r, g, b, 1'b0, 1'b0, '0};
      return v;
   endfunction

   // result checker
   always @(posedge clock) begin
      logic [24:0] want;
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(10, 60);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               $error("unexpected word %h flat %b", rsp_tdata, rsp_tuser);
               failed = 1'b1;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tuser !== want[24]) begin
                  $error("flat_table expected %b actual %b", want[24], rsp_tuser);
                  failed = 1'b1;
               end
               if (rsp_tdata[7:0] !== want[7:0]) begin
                  $error("out_red expected %0d actual %0d", want[7:0], rsp_tdata[7:0]);
                  failed = 1'b1;
               end
               if (rsp_tdata[15:8] !== want[15:8]) begin
                  $error("out_green expected %0d actual %0d", want[15:8], rsp_tdata[15:8]);
                  failed = 1'b1;
               end
               if (rsp_tdata[23:16] !== want[23:16]) begin
                  $error("out_blue expected %0d actual %0d", want[23:16], rsp_tdata[23:16]);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      vector_type directed [$];
      vector_type v;
      int         words;
      cycle_count = 0;
      failed      = 1'b0;
      stall_pct   = 0;
      stall_left  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      lut_min     = 16'hffff;
      lut_max     = 16'h0000;
      for (int r = 0; r < NROWS; r++)
         for (int c = 0; c < 3; c++) lut_entry[r][c] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, single value, ramp, extremes, ignored rows
      v = pixel_word(8'd0, 8'd128, 8'd255);
      v.known = 1'b1; v.exp_flat = 1'b1; v.exp_pix = '0;
      directed.insert(directed.size(), v);
      directed.insert(directed.size(), row_word(8'd0, 16'd7, 16'd7, 16'd7));
      v.exp_flat = 1'b1;
      directed.insert(directed.size(), v);
      directed.insert(directed.size(), row_word(8'd32, 16'hffff, 16'h0000, 16'h1234));
      directed.insert(directed.size(), row_word(8'd255, 16'h0000, 16'hffff, 16'h0000));
      directed.insert(directed.size(), v);
      for (int r = 0; r < NROWS; r++)
         directed.insert(directed.size(),
                         row_word(r[7:0], (r == NROWS - 1) ? 16'hffff : 16'(r * 2048),
                                  16'(16'hffff - r * 2048), 16'h8000));
      directed[directed.size() - 1].ent_g = 16'h0000;
      v = pixel_word(8'd0, 8'd0, 8'd0);
      v.known = 1'b1; v.exp_pix = '{blue: 8'd127, green: 8'd255, red: 8'd0};
      directed.insert(directed.size(), v);
      v = pixel_word(8'd255, 8'd255, 8'd255);
      v.known = 1'b1; v.exp_pix = '{blue: 8'd127, green: 8'd0, red: 8'd255};
      directed.insert(directed.size(), v);
      directed.insert(directed.size(), pixel_word(8'd1, 8'd127, 8'd254));
      directed.insert(directed.size(), pixel_word(8'haa, 8'h55, 8'h80));
      foreach (directed[i]) send_word(directed[i], 1'b0);

      // hold off until every directed result has come
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);

      // random: table reloads with random span and pixel bursts
      words = 0;
      while (words < RAND_WORDS) begin
         logic [15:0] base, mask;
         stall_pct = ($urandom_range(0, 2) == 0) ? 3 : 0;
         mask = 16'hffff >> $urandom_range(0, 15);
         base = 16'($urandom);
         for (int r = 0; r < NROWS; r++) begin
            send_word(row_word(r[7:0], 16'(base + ($urandom & mask)),
                               16'(base + ($urandom & mask)),
                               16'(base + ($urandom & mask))), 1'b1);
            words++;
         end
         repeat ($urandom_range(10, 40)) begin
            if ($urandom_range(0, 9) == 0)
               v = row_word(8'($urandom_range(0, 1) ? $urandom_range(NROWS, 255)
                                                    : $urandom_range(0, NROWS - 1)),
                            16'($urandom), 16'($urandom), 16'($urandom));
            else
               v = pixel_word(8'($urandom), 8'($urandom), 8'($urandom));
            send_word(v, 1'b1);
            words++;
         end
         // at random, about one burst in four, hold off until it has drained
         if ($urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_pixels.size() != 0) @(posedge clock);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
